### rtl/tam_pkg.sv
// Shared types and constants for the three-axis moving average block.
// Operation and axis codes, the lane control bundle. No dependencies.
package tam_pkg;

	localparam int NUM_AXES   = 3;
	localparam int DATA_W     = 16;
	// Widest ring address; a lane uses only the low bits its depth needs.
	localparam int ADDR_MAX_W = 8;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_INIT   = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	localparam logic [1:0] AXIS_AZ = 2'd0;
	localparam logic [1:0] AXIS_EL = 2'd1;
	localparam logic [1:0] AXIS_RL = 2'd2;

	typedef struct packed {
		logic                  rd;    // read the ring entry at addr
		logic                  push;  // replace entry at addr with a sample, update sum
		logic                  fill;  // write fill value at addr, load sum = value * N
		logic [ADDR_MAX_W-1:0] addr;
	} lane_ctl_t;

endpackage

### rtl/tam_div.sv
// Divide of a signed running sum by the window length, one register stage,
// truncated toward zero (reciprocal multiply). Uses tam_pkg.
module tam_div
	import tam_pkg::*;
#(
	parameter int WINDOW = 16
) (
	input  logic                                   clk,
	input  logic signed [DATA_W+$clog2(WINDOW)-1:0] sum,
	output logic signed [DATA_W-1:0]                quo
);

	localparam int CW    = $clog2(WINDOW);
	localparam int SUM_W = DATA_W + CW;
	localparam int K     = SUM_W + CW;
	localparam int M_W   = SUM_W + 2;
	localparam int P_W   = SUM_W + M_W;
	// ceil(2^K / N) is exact for every magnitude below 2^SUM_W
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

	logic [SUM_W-1:0]  mag;
	logic [P_W-1:0]    prod_s1;
	logic              neg_s1;
	logic [DATA_W-1:0] q_mag;

	assign mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

	always_ff @(posedge clk) begin
		prod_s1 <= P_W'(mag) * P_W'(RECIP);
		neg_s1  <= sum[SUM_W-1];
	end

	assign q_mag = prod_s1[K+DATA_W-1:K];
	assign quo   = neg_s1 ? (~q_mag + DATA_W'(1)) : q_mag;

endmodule

### rtl/tam_lane.sv
// One axis: ring store of the last N samples, running sum and divider.
// Uses tam_pkg and tam_div.
module tam_lane
	import tam_pkg::*;
#(
	parameter int WINDOW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] wdata,
	output logic signed [DATA_W-1:0] avg
);

	localparam int AW    = $clog2(WINDOW);
	localparam int SUM_W = DATA_W + AW;
	localparam logic signed [SUM_W-1:0] N_S = SUM_W'(WINDOW);

	logic        [DATA_W-1:0] ring_mem [WINDOW];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  wdata_ext;
	logic signed [SUM_W-1:0]  fill_sum;
	logic [AW-1:0]            addr;

	assign addr      = ctl.addr[AW-1:0];
	assign wdata_ext = SUM_W'(wdata);
	assign fill_sum  = wdata_ext * N_S;

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.fill) begin
			ring_mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rd_q <= ring_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.fill) begin
			sum_q <= fill_sum;
		end else if (ctl.push) begin
			// rd_q holds the entry being replaced
			sum_q <= sum_q - SUM_W'(rd_q) + wdata_ext;
		end
	end

	tam_div #(
		.WINDOW(WINDOW)
	) u_div (
		.clk(clk),
		.sum(sum_q),
		.quo(avg)
	);

endmodule

### rtl/three_axis_moving_average_top.sv
// Three-axis boxcar moving average: control sequencer, three lanes, result register.
// Uses tam_pkg and tam_lane.
//
//   channel | handshake          | fields
//   --------+--------------------+---------------------------------------------------
//   in      | in_valid/in_ready  | operation, az_in, el_in, rl_in, axis_sel, flush_in
//   out     | out_valid/out_ready| az_avg, el_avg, rl_avg
//
// Sample item: accept, ring read-modify-write, multiply, result load.
// Init/flush item: accept, fill of every ring entry, multiply, result load; the fill writes one ring entry per cycle.
// Unknown operation or axis: accept, then multiply and result load with no ring access.
// After reset every ring entry is swept to zero before in_ready rises.
// A waiting result holds the block in its last step until out_ready.
module three_axis_moving_average_top
	import tam_pkg::*;
#(
	parameter int WINDOW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic signed [DATA_W-1:0] az_in,
	input  logic signed [DATA_W-1:0] el_in,
	input  logic signed [DATA_W-1:0] rl_in,
	input  logic [1:0]               axis_sel,
	input  logic signed [DATA_W-1:0] flush_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] az_avg,
	output logic signed [DATA_W-1:0] el_avg,
	output logic signed [DATA_W-1:0] rl_avg
);

	localparam int AW = $clog2(WINDOW);
	localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_UPD   = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                   state_q;
	state_t                   state_d;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            cnt_q;
	logic [NUM_AXES-1:0]      mask_q;
	logic [NUM_AXES-1:0]      mask_d;
	logic signed [DATA_W-1:0] data_q  [NUM_AXES];
	logic signed [DATA_W-1:0] data_d  [NUM_AXES];
	lane_ctl_t                lane_ctl  [NUM_AXES];
	logic signed [DATA_W-1:0] lane_wdata [NUM_AXES];
	logic signed [DATA_W-1:0] lane_avg  [NUM_AXES];
	logic                     accept;
	logic                     out_load;
	logic                     init_d;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	// decode of an accepted item
	always_comb begin
		state_d = ST_DIV;
		mask_d  = '0;
		init_d  = 1'b0;
		data_d[0] = az_in;
		data_d[1] = el_in;
		data_d[2] = rl_in;
		case (op_t'(operation))
			OP_SAMPLE: begin
				state_d = ST_UPD;
			end
			OP_INIT: begin
				state_d = ST_FILL;
				mask_d  = '1;
				init_d  = 1'b1;
			end
			OP_FLUSH: begin
				data_d[0] = flush_in;
				data_d[1] = flush_in;
				data_d[2] = flush_in;
				case (axis_sel)
					AXIS_AZ: begin
						state_d = ST_FILL;
						mask_d  = 3'b001;
					end
					AXIS_EL: begin
						state_d = ST_FILL;
						mask_d  = 3'b010;
					end
					AXIS_RL: begin
						state_d = ST_FILL;
						mask_d  = 3'b100;
					end
					default: begin
						state_d = ST_DIV;
					end
				endcase
			end
			default: begin
				state_d = ST_DIV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + AW'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= state_d;
						cnt_q   <= '0;
						if (init_d) begin
							pos_q <= '0;
						end
					end
				end
				ST_UPD: begin
					pos_q   <= (pos_q == LAST) ? '0 : pos_q + AW'(1);
					state_q <= ST_DIV;
				end
				ST_FILL: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + AW'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= mask_d;
			for (int i = 0; i < NUM_AXES; i++) begin
				data_q[i] <= data_d[i];
			end
		end
	end

	// lane control; the reset sweep writes zero into every lane
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			lane_ctl[i].rd   = accept && (op_t'(operation) == OP_SAMPLE);
			lane_ctl[i].push = (state_q == ST_UPD);
			lane_ctl[i].fill = (state_q == ST_CLEAR) || ((state_q == ST_FILL) && mask_q[i]);
			lane_ctl[i].addr = ((state_q == ST_CLEAR) || (state_q == ST_FILL))
				? ADDR_MAX_W'(cnt_q) : ADDR_MAX_W'(pos_q);
			lane_wdata[i]    = (state_q == ST_CLEAR) ? '0 : data_q[i];
		end
	end

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		tam_lane #(
			.WINDOW(WINDOW)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(lane_ctl[g]),
			.wdata(lane_wdata[g]),
			.avg(lane_avg[g])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			az_avg <= lane_avg[0];
			el_avg <= lane_avg[1];
			rl_avg <= lane_avg[2];
		end
	end

endmodule
